[src/bsfn_pkg.sv]
package bsfn_pkg;

  // Bitmap geometry
  localparam int SLOT_COUNT = 2048;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;

  // Field and index widths
  localparam int IDX_W      = 11;
  localparam int START_W    = IDX_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_SEL_W = $clog2(WORD_COUNT);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_SEL_W-1:0] wsel_t;
  typedef logic [BIT_W-1:0]      bsel_t;

  localparam wsel_t LAST_WORD = wsel_t'(WORD_COUNT - 1);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_FIND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_MODIFY,
    ST_SCAN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic launch;      // read the word under the pointer
    logic write_back;  // write the modified word for set or clear
    logic advance;     // step the scan to the next word
    logic finish;      // post the result of the current item
    logic finish_miss; // post an empty result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic past_end;  // find-next starts beyond the last slot
    logic scan_hit;  // current scan word holds a marked slot
    logic last_word; // scan pointer sits on the last word
  } status_t;

endpackage

[src/bsfn_ram.sv]
module bsfn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bsfn_dp.sv]
module bsfn_dp import bsfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [1:0]       opcode,
  input  logic [IDX_W-1:0] slot_index,
  input  logic             from_start,
  output logic             done,
  output logic             found,
  output logic [IDX_W-1:0] found_index
);

  op_t              op;
  logic             in_range;
  logic             past_end;
  wsel_t            word_ptr;
  bsel_t            bit_sel;
  logic             first;
  logic             rd_valid;
  logic [WORD_COUNT-1:0] word_valid;

  logic [START_W-1:0] start_pos;
  logic [START_W-1:0] pos;
  wsel_t            raddr;
  word_t            rdata;
  word_t            eff_word;
  word_t            scan_word;
  word_t            bit_onehot;
  logic             we;
  word_t            wdata;
  bsel_t            low_bit;
  logic             scan_hit;

  // Work out where find-next starts and which word an item touches
  always_comb begin
    start_pos = from_start ? '0 : START_W'(slot_index) + START_W'(1);
    pos       = (op_t'(opcode) == OP_FIND) ? start_pos : START_W'(slot_index);
  end

  // Capture the item and step the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= op_t'(opcode);
      in_range <= 32'(slot_index) < SLOT_COUNT;
      past_end <= 32'(start_pos) >= SLOT_COUNT;
      word_ptr <= wsel_t'(pos >> BIT_W);
      bit_sel  <= pos[BIT_W-1:0];
      first    <= 1'b1;
    end else if (cmd.advance) begin
      word_ptr <= word_ptr + wsel_t'(1);
      first    <= 1'b0;
    end
  end

  // Read the pointed word on launch, the following one while scanning
  assign raddr = cmd.launch ? word_ptr : word_ptr + wsel_t'(1);

  bsfn_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(word_ptr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Track which words were ever written; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (we) begin
        word_valid[word_ptr] <= 1'b1;
      end
      rd_valid <= word_valid[raddr];
    end
  end

  assign eff_word   = rd_valid ? rdata : '0;
  assign bit_onehot = word_t'(1) << bit_sel;

  // Modify the word for set and clear
  always_comb begin
    we    = cmd.write_back && in_range && (op == OP_SET || op == OP_CLEAR);
    wdata = (op == OP_SET) ? (eff_word | bit_onehot) : (eff_word & ~bit_onehot);
  end

  // Mask bits below the start in the first word, then pick the lowest marked bit
  always_comb begin
    scan_word = first ? (eff_word & (~word_t'(0) << bit_sel)) : eff_word;
    scan_hit  = |scan_word;
    low_bit   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (scan_word[i]) begin
        low_bit = bsel_t'(i);
      end
    end
  end

  assign status.op        = op;
  assign status.past_end  = past_end;
  assign status.scan_hit  = scan_hit;
  assign status.last_word = (word_ptr == LAST_WORD);

  // Post the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish | cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_miss) begin
      found       <= 1'b0;
      found_index <= '0;
    end else if (cmd.finish) begin
      unique case (op)
        OP_TEST: begin
          found       <= in_range & eff_word[bit_sel];
          found_index <= '0;
        end
        OP_FIND: begin
          found       <= scan_hit;
          found_index <= scan_hit ? IDX_W'({word_ptr, low_bit}) : '0;
        end
        default: begin
          found       <= 1'b0;
          found_index <= '0;
        end
      endcase
    end
  end

endmodule

[src/bsfn_ctrl.sv]
module bsfn_ctrl import bsfn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (status.op == OP_FIND) begin
          if (status.past_end) begin
            cmd.finish_miss = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            cmd.launch = 1'b1;
            state_next = ST_SCAN;
          end
        end else begin
          cmd.launch = 1'b1;
          state_next = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        cmd.write_back = 1'b1;
        cmd.finish     = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_hit || status.last_word) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/bitmap_slot_set_find_next.sv]
// Slot occupancy bitmap with set, clear, test and find-next, kept as 32-bit
// words in a RAM and all clear after reset. An item is taken when start is
// high and busy is low; its one result shows on found and found_index while
// done is high for a single cycle, and cannot be held off by the receiver.
// Set, clear and test read the word, then modify or compare it. Find-next
// scans words from the start word up to the hit or the last word: the
// scan reads one word per cycle through the RAM's single read port. A
// find-next starting beyond the last slot answers without a scan. A new
// item may be started on the cycle done is high.
module bitmap_slot_set_find_next import bsfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [IDX_W-1:0] slot_index,
  input  logic             from_start,
  output logic             done,
  output logic             found,
  output logic [IDX_W-1:0] found_index
);

  cmd_t    cmd;
  status_t status;

  bsfn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  bsfn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .slot_index (slot_index),
    .from_start (from_start),
    .done       (done),
    .found      (found),
    .found_index(found_index)
  );

endmodule

[test/tb_bitmap_slot_set_find_next.sv]
`timescale 1ns / 1ps

module tb_bitmap_slot_set_find_next;
  import bsfn_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL   = 300;   // last items go back to back
  localparam int DRAIN_CYCLES = 80;    // longer than a full scan
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } answer_t;

  // Scoreboard: shadow bitmap plus the answers still owed by the block
  class slot_map_board;
    word_t   occ [WORD_COUNT];
    answer_t owed [$];
    int      mismatches;
    int      taken;
    int      answered;
    int      find_hits;
    int      per_op [4];

    function new();
      foreach (occ[i]) occ[i] = '0;
      foreach (per_op[i]) per_op[i] = 0;
      mismatches = 0;
      taken      = 0;
      answered   = 0;
      find_hits  = 0;
    endfunction

    // Apply one accepted item to the shadow bitmap and queue its answer
    function void note(op_t op, logic [IDX_W-1:0] slot, logic fs);
      answer_t ans;
      int      s;
      ans = '0;
      taken++;
      per_op[op]++;
      case (op)
        OP_SET:   occ[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
        OP_CLEAR: occ[slot / WORD_BITS][slot % WORD_BITS] = 1'b0;
        OP_TEST:  ans.hit = occ[slot / WORD_BITS][slot % WORD_BITS];
        default: begin
          // scan upward; a start past the last slot finds nothing
          s = fs ? 0 : int'(slot) + 1;
          while (s < SLOT_COUNT && !ans.hit) begin
            if (occ[s / WORD_BITS][s % WORD_BITS]) begin
              ans.hit = 1'b1;
              ans.idx = s[IDX_W-1:0];
            end
            s++;
          end
          if (ans.hit) find_hits++;
        end
      endcase
      owed.push_back(ans);
    endfunction

    // Compare one posted result against the oldest owed answer
    function void check(logic hit, logic [IDX_W-1:0] idx);
      answer_t want;
      if (owed.size() == 0) begin
        $error("result with nothing pending: found=%0b found_index=%0d", hit, idx);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      answered++;
      if (hit !== want.hit) begin
        $error("found: expected %0b, got %0b", want.hit, hit);
        mismatches++;
      end
      if (idx !== want.idx) begin
        $error("found_index: expected %0d, got %0d", want.idx, idx);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] slot_index;
  logic             from_start;
  logic             done;
  logic             found;
  logic [IDX_W-1:0] found_index;

  slot_map_board board;

  bitmap_slot_set_find_next DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .slot_index  (slot_index),
    .from_start  (from_start),
    .done        (done),
    .found       (found),
    .found_index (found_index)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(op_t op, logic [IDX_W-1:0] slot, logic fs);
    start      <= 1'b1;
    opcode     <= op;
    slot_index <= slot;
    from_start <= fs;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start for the requested number of cycles, with junk on the fields
  task automatic hold_off(int cycles);
    start      <= 1'b0;
    opcode     <= 2'($urandom_range(0, 3));
    slot_index <= IDX_W'($urandom_range(0, SLOT_COUNT - 1));
    from_start <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // Corners: empty map, edge slots, word boundaries, scan past the end
  task automatic run_directed();
    send_item(OP_FIND,  11'd0,    1'b1);
    send_item(OP_FIND,  11'd0,    1'b0);
    send_item(OP_TEST,  11'd0,    1'b0);
    send_item(OP_TEST,  11'd2047, 1'b0);
    send_item(OP_SET,   11'd0,    1'b0);
    send_item(OP_SET,   11'd2047, 1'b1);
    send_item(OP_SET,   11'd31,   1'b0);
    send_item(OP_SET,   11'd32,   1'b1);
    send_item(OP_TEST,  11'd0,    1'b1);
    send_item(OP_TEST,  11'd2047, 1'b0);
    send_item(OP_TEST,  11'd33,   1'b0);
    send_item(OP_FIND,  11'd1234, 1'b1);
    send_item(OP_FIND,  11'd0,    1'b0);
    send_item(OP_FIND,  11'd31,   1'b0);
    send_item(OP_FIND,  11'd32,   1'b0);
    send_item(OP_FIND,  11'd2046, 1'b0);
    send_item(OP_FIND,  11'd2047, 1'b0);
    send_item(OP_CLEAR, 11'd0,    1'b1);
    send_item(OP_CLEAR, 11'd2047, 1'b0);
    send_item(OP_CLEAR, 11'd2047, 1'b0);
    send_item(OP_TEST,  11'd0,    1'b0);
    send_item(OP_FIND,  11'd32,   1'b0);
    send_item(OP_CLEAR, 11'd31,   1'b0);
    send_item(OP_CLEAR, 11'd32,   1'b0);
    send_item(OP_FIND,  11'd0,    1'b1);
  endtask

  // Bursts that work one small window of words, filling or draining it,
  // mixed with bursts spread over the whole map
  task automatic run_random();
    int sent;
    int burst_len;
    int k;
    int base;
    int span;
    int set_pct;
    int rest;
    int roll;
    bit wide;
    bit gappy;
    op_t op;
    logic [IDX_W-1:0] slot;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(10, 40);
      wide      = ($urandom_range(0, 3) == 0);
      gappy     = ($urandom_range(0, 2) != 0);
      base      = $urandom_range(0, WORD_COUNT - 1) * WORD_BITS;
      span      = $urandom_range(1, 3) * WORD_BITS;
      set_pct   = $urandom_range(20, 70);
      rest      = 100 - set_pct;
      for (k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < set_pct)                 op = OP_SET;
        else if (roll < set_pct + rest / 3) op = OP_CLEAR;
        else if (roll < set_pct + 2 * rest / 3) op = OP_TEST;
        else                                op = OP_FIND;
        if (wide) slot = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
        else      slot = IDX_W'((base + $urandom_range(0, span - 1)) % SLOT_COUNT);
        if (gappy && sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
          hold_off($urandom_range(1, 8));
        send_item(op, slot, $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  // Watch both handshakes and feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) board.check(found, found_index);
      if (start && busy === 1'b0) board.note(op_t'(opcode), slot_index, from_start);
    end
  end

  // Give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || done === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    board      = new();
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_SET;
    slot_index = '0;
    from_start = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();
    start <= 1'b0;

    // Wait out the owed answers, then watch for stray results
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d set, %0d clear, %0d test, %0d find (%0d hits).",
             board.taken, board.per_op[OP_SET], board.per_op[OP_CLEAR],
             board.per_op[OP_TEST], board.per_op[OP_FIND], board.find_hits);
    $display("Checked %0d results, %0d mismatches.", board.answered, board.mismatches);
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
src/bsfn_pkg.sv
src/bsfn_ram.sv
src/bsfn_dp.sv
src/bsfn_ctrl.sv
src/bitmap_slot_set_find_next.sv
test/tb_bitmap_slot_set_find_next.sv
